// ----- hdl/mctc_pkg.sv -----
// Package: shared types, codes and widths of the mip chain texel counter.
`default_nettype none
package mctc_pkg;

  localparam int SIDE_W  = 15;
  localparam int LAYER_W = 12;
  localparam int LEVEL_W = 5;
  localparam int CHAIN_W = 4;
  localparam int TOTAL_W = 44;
  localparam int PROD_W  = 2 * SIDE_W;
  localparam int TERM_W  = PROD_W + SIDE_W;
  localparam int WRAP_W  = 32;

  localparam int DEF_MAX_LEVELS = 16;

  // texture type codes
  localparam logic [3:0] TT_1D         = 4'd0;
  localparam logic [3:0] TT_2D         = 4'd1;
  localparam logic [3:0] TT_3D         = 4'd2;
  localparam logic [3:0] TT_CUBE       = 4'd3;
  localparam logic [3:0] TT_1D_ARRAY   = 4'd4;
  localparam logic [3:0] TT_2D_ARRAY   = 4'd5;
  localparam logic [3:0] TT_CUBE_ARRAY = 4'd6;
  localparam logic [3:0] TT_2DMS       = 4'd7;
  localparam logic [3:0] TT_2DMS_ARRAY = 4'd8;

  // height operand source
  localparam logic [1:0] Y_ONE    = 2'd0;
  localparam logic [1:0] Y_MIP    = 2'd1;
  localparam logic [1:0] Y_LAYERS = 2'd2;
  localparam logic [1:0] Y_RAW    = 2'd3;

  // depth operand source
  localparam logic [1:0] Z_ONE    = 2'd0;
  localparam logic [1:0] Z_MIP    = 2'd1;
  localparam logic [1:0] Z_LAYERS = 2'd2;
  localparam logic [1:0] Z_RAW    = 2'd3;

  typedef struct packed {
    logic [3:0]         texture_type;
    logic [SIDE_W-1:0]  base_width;
    logic [SIDE_W-1:0]  base_height;
    logic [SIDE_W-1:0]  base_depth;
    logic [LAYER_W-1:0] layer_count;
    logic [LEVEL_W-1:0] first_level;
    logic [LEVEL_W-1:0] level_count;
  } mctc_req_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] total_texels;
    logic [CHAIN_W-1:0] chain_length;
    logic               exceeds_32_bits;
  } mctc_rsp_t;

  typedef struct packed {
    logic [CHAIN_W-1:0] chain;
    logic               x_raw;
    logic [1:0]         y_sel;
    logic [1:0]         z_sel;
  } mctc_dec_t;

  typedef struct packed {
    logic clear;
    logic mul_xy;
    logic mul_z;
    logic acc_add;
  } mctc_op_t;

  // position of the highest set bit; zero reads as zero
  function automatic logic [CHAIN_W-1:0] floor_log2(input logic [SIDE_W-1:0] v);
    logic [CHAIN_W-1:0] r;
    r = '0;
    for (int i = 0; i < SIDE_W; i++) begin
      if (v[i]) r = CHAIN_W'(i);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/mctc_decode.sv -----
// Type decode: chain length and operand sources for one request.
`default_nettype none
module mctc_decode
  import mctc_pkg::*;
(
  input  mctc_req_t req,
  output mctc_dec_t dec
);

  logic [SIDE_W-1:0] max_wh;
  logic [SIDE_W-1:0] max_whd;
  logic [SIDE_W-1:0] w1;

  always_comb begin
    w1      = (req.base_width == '0) ? SIDE_W'(1) : req.base_width;
    max_wh  = (req.base_height > w1) ? req.base_height : w1;
    max_whd = (req.base_depth > max_wh) ? req.base_depth : max_wh;
  end

  always_comb begin
    dec = '0;
    case (req.texture_type)
      TT_1D: begin
        dec.chain = floor_log2(w1) + CHAIN_W'(1);
        dec.y_sel = Y_ONE;
        dec.z_sel = Z_ONE;
      end
      TT_2D, TT_CUBE: begin
        dec.chain = floor_log2(max_wh) + CHAIN_W'(1);
        dec.y_sel = Y_MIP;
        dec.z_sel = Z_ONE;
      end
      TT_3D: begin
        dec.chain = floor_log2(max_whd) + CHAIN_W'(1);
        dec.y_sel = Y_MIP;
        dec.z_sel = Z_MIP;
      end
      TT_1D_ARRAY: begin
        dec.chain = floor_log2(w1) + CHAIN_W'(1);
        dec.y_sel = Y_LAYERS;
        dec.z_sel = Z_ONE;
      end
      TT_2D_ARRAY, TT_CUBE_ARRAY: begin
        dec.chain = floor_log2(max_wh) + CHAIN_W'(1);
        dec.y_sel = Y_MIP;
        dec.z_sel = Z_LAYERS;
      end
      TT_2DMS: begin
        dec.chain = CHAIN_W'(1);
        dec.x_raw = 1'b1;
        dec.y_sel = Y_RAW;
        dec.z_sel = Z_ONE;
      end
      TT_2DMS_ARRAY: begin
        dec.chain = CHAIN_W'(1);
        dec.x_raw = 1'b1;
        dec.y_sel = Y_RAW;
        dec.z_sel = Z_LAYERS;
      end
      default: begin
        // unknown type: no level contributes
        dec = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/mctc_mul_acc.sv -----
// Shared multiplier with product, term and accumulator registers.
`default_nettype none
module mctc_mul_acc
  import mctc_pkg::*;
#(
  parameter int ACC_W = TERM_W + 5
) (
  input  logic              clk,
  input  mctc_op_t          op,
  input  logic [SIDE_W-1:0] x,
  input  logic [SIDE_W-1:0] y,
  input  logic [SIDE_W-1:0] z,
  output logic [ACC_W-1:0]  acc
);

  logic [PROD_W-1:0] prod;
  logic [TERM_W-1:0] term;
  logic [PROD_W-1:0] opa;
  logic [SIDE_W-1:0] opb;
  logic [TERM_W-1:0] mult;

  // first pass x*y, second pass (x*y)*z through the same multiplier
  always_comb begin
    opa  = op.mul_z ? prod : PROD_W'(x);
    opb  = op.mul_z ? z : y;
    mult = TERM_W'(opa) * TERM_W'(opb);
  end

  always_ff @(posedge clk) begin
    if (op.clear) begin
      acc  <= '0;
      term <= '0;
    end else begin
      if (op.acc_add) acc <= acc + ACC_W'(term);
      if (op.mul_xy) prod <= mult[PROD_W-1:0];
      if (op.mul_z) term <= mult;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/mip_chain_texel_counter.sv -----
// Top level: request register, level sequencer and response register.
//
// Each request runs through one shared multiplier, with an x*y step and a
// times-z step for each mip level that lies inside both the requested range
// and the full chain (the previous level's term is added to the accumulator
// in the x*y step), plus the accept, the last range check and the finish.
// The chain never holds more than fifteen levels. req_stall is high while a
// request is in flight. The response sits in an output register, so the next
// request is taken while a finished response still waits on rsp_stall.
// total_texels saturates at 2^44-1; exceeds_32_bits flags a sum above
// 2^32-1. level_count is clamped to MAX_LEVELS.
`default_nettype none
module mip_chain_texel_counter
  import mctc_pkg::*;
#(
  parameter int MAX_LEVELS = DEF_MAX_LEVELS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  mctc_req_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output mctc_rsp_t rsp
);

  localparam int CNT_W = $clog2(MAX_LEVELS + 1);
  localparam int LV_W  = $clog2((1 << LEVEL_W) + MAX_LEVELS);
  localparam int ACC_W = TERM_W + CNT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MULA = 2'd1;
  localparam logic [1:0] S_MULB = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]        state, state_next;
  mctc_req_t         req_q;
  logic [LV_W-1:0]   lv;
  logic [CNT_W-1:0]  rem;
  mctc_dec_t         dec;
  mctc_op_t          op;
  logic [SIDE_W-1:0] x, y, z;
  logic [ACC_W-1:0]  acc;
  logic              active;
  logic              accept;
  logic              fire;
  logic [CNT_W-1:0]  count_sat;
  logic [3:0]        sh;

  function automatic logic [SIDE_W-1:0] mip_side(input logic [SIDE_W-1:0] side,
                                                 input logic [3:0] amt);
    logic [SIDE_W-1:0] s;
    s = side >> amt;
    return (s == '0) ? SIDE_W'(1) : s;
  endfunction

  mctc_decode u_decode (
    .req (req_q),
    .dec (dec)
  );

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign fire      = !rsp_valid || !rsp_stall;
  assign active    = (rem != '0) && (lv < LV_W'(dec.chain));
  assign sh        = lv[3:0];

  always_comb begin
    if ((LEVEL_W + 1)'(req.level_count) > (LEVEL_W + 1)'(MAX_LEVELS)) begin
      count_sat = CNT_W'(MAX_LEVELS);
    end else begin
      count_sat = CNT_W'(req.level_count);
    end
  end

  // operand selection for the current level
  always_comb begin
    x = dec.x_raw ? req_q.base_width : mip_side(req_q.base_width, sh);
    case (dec.y_sel)
      Y_MIP:    y = mip_side(req_q.base_height, sh);
      Y_LAYERS: y = SIDE_W'(req_q.layer_count);
      Y_RAW:    y = req_q.base_height;
      default:  y = SIDE_W'(1);
    endcase
    case (dec.z_sel)
      Z_MIP:    z = mip_side(req_q.base_depth, sh);
      Z_LAYERS: z = SIDE_W'(req_q.layer_count);
      Z_RAW:    z = req_q.base_depth;
      default:  z = SIDE_W'(1);
    endcase
  end

  always_comb begin
    op         = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          op.clear   = 1'b1;
          state_next = S_MULA;
        end
      end
      S_MULA: begin
        op.acc_add = 1'b1;
        if (active) begin
          op.mul_xy  = 1'b1;
          state_next = S_MULB;
        end else begin
          state_next = S_FIN;
        end
      end
      S_MULB: begin
        op.mul_z   = 1'b1;
        state_next = S_MULA;
      end
      S_FIN: begin
        if (fire) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  mctc_mul_acc #(
    .ACC_W (ACC_W)
  ) u_mul_acc (
    .clk (clk),
    .op  (op),
    .x   (x),
    .y   (y),
    .z   (z),
    .acc (acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_FIN && fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
      lv    <= LV_W'(req.first_level);
      rem   <= count_sat;
    end else if (state == S_MULB) begin
      lv  <= lv + LV_W'(1);
      rem <= rem - CNT_W'(1);
    end
    if (state == S_FIN && fire) begin
      rsp.total_texels    <= (|acc[ACC_W-1:TOTAL_W]) ? '1 : acc[TOTAL_W-1:0];
      rsp.chain_length    <= dec.chain;
      rsp.exceeds_32_bits <= |acc[ACC_W-1:WRAP_W];
    end
  end

endmodule
`default_nettype wire

// ----- bench/mip_chain_texel_counter_tb.sv -----
// Testbench for mip_chain_texel_counter: queued requests, random handshakes, field-exact checks.
`timescale 1ns / 1ps
module mip_chain_texel_counter_tb;
  import mctc_pkg::*;

  localparam int LEVEL_CAP = DEF_MAX_LEVELS;
  localparam int MAX_WAIT = 18;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_REQS = 1380;
  localparam int REQ_BITS = $bits(mctc_req_t);
  localparam logic [3:0] TT_FIRST_UNUSED = 4'd9;
  localparam logic [3:0] TT_LAST_UNUSED = 4'd15;
  localparam logic [63:0] TOTAL_MAX = (64'd1 << TOTAL_W) - 64'd1;
  localparam logic [63:0] WRAP_MAX = (64'd1 << WRAP_W) - 64'd1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  mctc_req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  mctc_rsp_t rsp;

  mctc_req_t req_backlog[$];
  mctc_rsp_t expected_totals[$];
  int reqs_issued = 0;
  int reqs_taken = 0;
  int totals_checked = 0;
  int mismatches = 0;
  logic req_fired = 1'b0;
  logic rsp_fired = 1'b0;

  int req_gap = 0;
  bit req_calm = 1'b0;
  int rsp_wait = 0;
  int rsp_hold_left = 0;
  bit rsp_calm = 1'b0;
  int totals_seen = 0;

  mip_chain_texel_counter dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always #5 clk = ~clk;

  function automatic int unsigned chain_for(input int unsigned widest);
    int unsigned n;
    n = 1;
    while (widest > 1) begin
      widest = widest >> 1;
      n++;
    end
    return n;
  endfunction

  // mipped side at a level, floored to one texel
  function automatic logic [63:0] mip_extent(input logic [SIDE_W-1:0] s, input int unsigned lv);
    int unsigned v;
    v = 32'(s) >> lv;
    return (v == 0) ? 64'd1 : 64'(v);
  endfunction

  function automatic mctc_rsp_t count_texels(input mctc_req_t r);
    mctc_rsp_t p;
    int unsigned levels, chain, widest, lv;
    logic [63:0] sum, x, y, z;
    logic [63:0] w, h, layers;
    w = 64'(r.base_width);
    h = 64'(r.base_height);
    layers = 64'(r.layer_count);
    levels = (r.level_count > LEVEL_CAP) ? LEVEL_CAP : r.level_count;
    widest = r.base_width;
    case (r.texture_type)
      TT_1D, TT_1D_ARRAY: chain = chain_for(widest);
      TT_2D, TT_CUBE, TT_2D_ARRAY, TT_CUBE_ARRAY: begin
        if (r.base_height > widest) widest = r.base_height;
        chain = chain_for(widest);
      end
      TT_3D: begin
        if (r.base_height > widest) widest = r.base_height;
        if (r.base_depth > widest) widest = r.base_depth;
        chain = chain_for(widest);
      end
      TT_2DMS, TT_2DMS_ARRAY: chain = 1;
      default: chain = 0;
    endcase
    sum = '0;
    for (int i = 0; i < levels; i++) begin
      lv = r.first_level + i;
      if (lv < chain) begin
        x = mip_extent(r.base_width, lv);
        y = 64'd1;
        z = 64'd1;
        case (r.texture_type)
          TT_2D, TT_CUBE: y = mip_extent(r.base_height, lv);
          TT_3D: begin
            y = mip_extent(r.base_height, lv);
            z = mip_extent(r.base_depth, lv);
          end
          TT_1D_ARRAY: y = layers;
          TT_2D_ARRAY, TT_CUBE_ARRAY: begin
            y = mip_extent(r.base_height, lv);
            z = layers;
          end
          TT_2DMS: begin
            x = w;
            y = h;
          end
          TT_2DMS_ARRAY: begin
            x = w;
            y = h;
            z = layers;
          end
          default: ;
        endcase
        sum += x * y * z;
      end
    end
    p.total_texels = (sum > TOTAL_MAX) ? '1 : sum[TOTAL_W-1:0];
    p.chain_length = CHAIN_W'(chain);
    p.exceeds_32_bits = (sum > WRAP_MAX);
    return p;
  endfunction

  task automatic offer(input logic [3:0] tt, input int w, input int h, input int d,
                       input int layers, input int first, input int count);
    mctc_req_t r;
    r.texture_type = tt;
    r.base_width = SIDE_W'(w);
    r.base_height = SIDE_W'(h);
    r.base_depth = SIDE_W'(d);
    r.layer_count = LAYER_W'(layers);
    r.first_level = LEVEL_W'(first);
    r.level_count = LEVEL_W'(count);
    req_backlog.push_back(r);
    reqs_issued++;
  endtask

  // mostly power-of-two-ish sizes, occasionally the whole field
  function automatic int rand_side();
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, (1 << SIDE_W) - 1);
    return $urandom_range(1, 1 << $urandom_range(0, 14));
  endfunction

  task automatic offer_random(input int n);
    mctc_req_t r;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        // noise: raw field values, unknown types, zero sides, long ranges
        r = REQ_BITS'({$urandom, $urandom, $urandom});
        case ($urandom_range(0, 5))
          0: r.base_width = '0;
          1: r.base_height = '0;
          2: r.layer_count = '0;
          default: ;
        endcase
        req_backlog.push_back(r);
        reqs_issued++;
      end else begin
        offer(4'($urandom_range(TT_1D, TT_2DMS_ARRAY)), rand_side(), rand_side(), rand_side(),
              $urandom_range(1, 1 << $urandom_range(0, 11)), $urandom_range(0, 15),
              $urandom_range(0, LEVEL_CAP));
      end
    end
  endtask

  // sender holds off until every queued request has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (reqs_taken != reqs_issued || totals_checked != reqs_taken);
  endtask

  task automatic flag_mismatch(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    $display("%0t mismatch %s: expected %0d actual %0d", $time, field, want, got);
  endtask

  // request side
  always @(negedge clk) begin
    logic keep, launch;
    if (!rst) begin
      keep = req_valid && !req_fired;
      launch = 1'b0;
      if (!keep) begin
        if (req_gap > 0) req_gap--;
        else if (req_backlog.size() > 0) launch = 1'b1;
      end
      if (launch) begin
        req <= req_backlog.pop_front();
        if ($urandom_range(0, 39) == 0) req_calm = !req_calm;
        req_gap = req_calm ? 0 : $urandom_range(0, MAX_WAIT);
      end
      req_valid <= keep || launch;
    end
  end

  // response side
  always @(negedge clk) begin
    if (!rst) begin
      if (rsp_hold_left > 0) rsp_hold_left--;
      if (rsp_fired) begin
        totals_seen++;
        // long hold-off so requests back up behind the output register
        if (totals_seen % 600 == 200) rsp_hold_left = 250;
        if ($urandom_range(0, 49) == 0) rsp_calm = !rsp_calm;
        rsp_wait = rsp_calm ? 0 : $urandom_range(0, MAX_WAIT);
      end else if (rsp_valid && rsp_wait > 0 && rsp_hold_left == 0) begin
        rsp_wait--;
      end
      rsp_stall <= (rsp_hold_left > 0) || (rsp_wait > 0);
    end
  end

  // transaction monitor and checker
  always @(posedge clk) begin
    mctc_rsp_t want;
    if (rst) begin
      req_fired <= 1'b0;
      rsp_fired <= 1'b0;
    end else begin
      req_fired <= req_valid && !req_stall;
      rsp_fired <= rsp_valid && !rsp_stall;
      if (req_valid && !req_stall) begin
        expected_totals.push_back(count_texels(req));
        reqs_taken <= reqs_taken + 1;
      end
      if (rsp_valid && !rsp_stall) begin
        totals_checked <= totals_checked + 1;
        if (expected_totals.size() == 0) begin
          mismatches++;
          $display("%0t unexpected result: expected none actual total %0d chain %0d flag %0d",
                   $time, rsp.total_texels, rsp.chain_length, rsp.exceeds_32_bits);
        end else begin
          want = expected_totals.pop_front();
          if (rsp.total_texels !== want.total_texels)
            flag_mismatch("total_texels", 64'(want.total_texels), 64'(rsp.total_texels));
          if (rsp.chain_length !== want.chain_length)
            flag_mismatch("chain_length", 64'(want.chain_length), 64'(rsp.chain_length));
          if (rsp.exceeds_32_bits !== want.exceeds_32_bits)
            flag_mismatch("exceeds_32_bits", 64'(want.exceeds_32_bits),
                          64'(rsp.exceeds_32_bits));
        end
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("mip_chain_texel_counter_tb NOT OK");
    $finish;
  end

  initial begin
    offer(TT_1D, 1, 1, 1, 1, 0, 1);
    offer(TT_1D, 32767, 0, 0, 0, 0, 16);
    offer(TT_2D, 16384, 16384, 1, 1, 0, 16);
    offer(TT_3D, 32767, 32767, 32767, 1, 0, 16);       // saturates the sum
    offer(TT_3D, 16384, 16384, 16384, 1, 0, 1);
    offer(TT_3D, 1024, 1024, 4096, 1, 0, 1);           // exactly 2^32
    offer(TT_3D, 1, 1, 32767, 1, 0, 16);
    offer(TT_CUBE, 0, 0, 5, 6, 0, 5);                  // zero mipped sides
    offer(TT_1D_ARRAY, 100, 7, 1, 0, 0, 8);            // zero layers
    offer(TT_1D_ARRAY, 32767, 1, 1, 4095, 0, 31);      // count clamps
    offer(TT_2D_ARRAY, 32767, 32767, 1, 4095, 0, 16);
    offer(TT_2D_ARRAY, 32767, 1, 1, 1, 14, 2);         // range runs off the chain
    offer(TT_CUBE_ARRAY, 512, 512, 1, 6, 3, 4);
    offer(TT_2DMS, 32767, 32767, 9, 1, 0, 16);
    offer(TT_2DMS, 640, 480, 1, 1, 1, 4);              // multisample past level 0
    offer(TT_2DMS_ARRAY, 32767, 32767, 1, 4095, 0, 1);
    offer(TT_2DMS_ARRAY, 64, 0, 1, 8, 0, 1);           // zero multisample side
    offer(TT_FIRST_UNUSED, 256, 256, 256, 4, 0, 8);
    offer(TT_LAST_UNUSED, 32767, 32767, 32767, 4095, 31, 31);
    offer(TT_2D, 300, 200, 1, 1, 2, 0);                // empty range
    offer(TT_2D, 32767, 32767, 1, 1, 31, 16);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    wait_drained();
    offer_random(RANDOM_REQS / 2);
    wait_drained();
    offer_random(RANDOM_REQS - RANDOM_REQS / 2);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_totals.size() != 0) begin
      mismatches++;
      $display("%0t %0d results never arrived", $time, expected_totals.size());
    end
    if (mismatches == 0) begin
      $display("mip_chain_texel_counter_tb OK");
    end else begin
      $display("mip_chain_texel_counter_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/mctc_pkg.sv
hdl/mctc_decode.sv
hdl/mctc_mul_acc.sv
hdl/mip_chain_texel_counter.sv
bench/mip_chain_texel_counter_tb.sv
